// ===== rtl/basin_region_classifier_assert.svh =====
// Assertion macros used by the classifier checker.
`ifndef BASIN_REGION_CLASSIFIER_ASSERT_SVH
`define BASIN_REGION_CLASSIFIER_ASSERT_SVH

// Same-cycle implication.
`define BRC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("classifier check failed");

// Next-cycle implication.
`define BRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("classifier check failed");

`endif

// ===== rtl/brc_pkg.sv =====
// ----------------------------------------------------------------------------
// brc_pkg
// Types, codes and constants of the basin region classifier.
// ----------------------------------------------------------------------------
package brc_pkg;

   localparam int MAX_DIMS    = 4;
   localparam int MAX_REGIONS = 16;
   localparam int MAX_BASINS  = 8;
   localparam int VALUE_WIDTH = 32;
   localparam int MASK_BITS   = 8;
   localparam int DIM_W       = 2;
   localparam int BASIN_LIMIT = (MAX_BASINS < MASK_BITS) ? MAX_BASINS : MASK_BITS;
   localparam logic [MASK_BITS-1:0] BASIN_SEL = MASK_BITS'((1 << BASIN_LIMIT) - 1);

   // restoring divider: quotient bits 16 down to 0
   localparam int DIV_STEPS = 17;
   localparam logic [16:0] Q_ONE = 17'h10000;
   localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;
   localparam logic [35:0] SPH_MAG_MAX = 36'h0_8000_0000;

   localparam logic [1:0] OP_CLASSIFY   = 2'd0;
   localparam logic [1:0] OP_WRITE_GEO  = 2'd1;
   localparam logic [1:0] OP_WRITE_KIND = 2'd2;

   localparam logic [1:0] KIND_RECT    = 2'd0;
   localparam logic [1:0] KIND_SPHERE  = 2'd1;
   localparam logic [1:0] KIND_ELLIPSE = 2'd2;
   localparam logic [1:0] KIND_UNUSED  = 2'd3;

   typedef enum logic [2:0] {
      CSR_DIMS, CSR_REGIONS, CSR_PMASK, CSR_STOP,
      CSR_PERIOD0, CSR_PERIOD1, CSR_PERIOD2, CSR_PERIOD3
   } csr_index_type;

   typedef enum logic [1:0] {MUL_RADIUS, MUL_MAG, MUL_QUOT} mul_src_type;

   typedef struct packed {
      logic        start_item;
      logic        wr_geo;
      logic        wr_kind;
      logic        latch_kind;
      logic        geo_sel;
      logic        latch_w0;
      logic        latch_w1;
      logic        calc_diff;
      logic        calc_red;
      logic        mul_en;
      mul_src_type mul_src;
      logic        r2_load;
      logic        sum_acc;
      logic        div_init;
      logic        div_step;
      logic        dim_inc;
      logic        region_hit;
      logic        reg_inc;
      logic        finish;
   } cmd_type;

   typedef struct packed {
      logic       region_done;
      logic       skip_region;
      logic [1:0] kind;
      logic       dim_first;
      logic       dim_last;
      logic       rect_fail;
      logic       sph_big;
      logic       acc_fail;
      logic       axis_zero;
      logic       mag_nz;
      logic       ell_over;
      logic       div_last;
      logic       q_over;
   } status_type;

endpackage

// ===== rtl/brc_ram.sv =====
// ----------------------------------------------------------------------------
// brc_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module brc_ram #(
   parameter  int WIDTH      = 32,
   parameter  int ADDR_WIDTH = 4,
   localparam int DEPTH      = 1 << ADDR_WIDTH
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/brc_ctrl.sv =====
// ----------------------------------------------------------------------------
// brc_ctrl
// Sequencer: walks regions and dimensions, drives the datapath commands.
// ----------------------------------------------------------------------------
module brc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          req_operation,
   input  brc_pkg::status_type status,
   output brc_pkg::cmd_type    cmd,
   output logic                busy
);

   typedef enum logic [4:0] {
      S_IDLE, S_REG_CHK, S_KIND, S_GEO0, S_GEO1, S_GEO2, S_DIFF, S_RED,
      S_RECT, S_RAD0, S_RAD1, S_SPH_SQ, S_SPH_ACC, S_ELL_CHK, S_ELL_DIV,
      S_ELL_Q, S_ELL_ACC, S_NEXT_DIM, S_NEXT_REG, S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      accept;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_operation)
                  brc_pkg::OP_CLASSIFY: begin
                     cmd.start_item = 1'b1;
                     state_in       = S_REG_CHK;
                  end
                  brc_pkg::OP_WRITE_GEO:  cmd.wr_geo  = 1'b1;
                  brc_pkg::OP_WRITE_KIND: cmd.wr_kind = 1'b1;
                  default: ;
               endcase
            end
         end
         S_REG_CHK: state_in = status.region_done ? S_FINISH : S_KIND;
         S_KIND: begin
            cmd.latch_kind = 1'b1;
            state_in       = status.skip_region ? S_NEXT_REG : S_GEO0;
         end
         S_GEO0: state_in = S_GEO1;
         S_GEO1: begin
            cmd.geo_sel  = 1'b1;
            cmd.latch_w0 = 1'b1;
            state_in     = S_GEO2;
         end
         S_GEO2: begin
            cmd.latch_w1 = 1'b1;
            state_in     = S_DIFF;
         end
         S_DIFF: begin
            cmd.calc_diff = 1'b1;
            state_in      = S_RED;
         end
         S_RED: begin
            cmd.calc_red = 1'b1;
            case (status.kind)
               brc_pkg::KIND_RECT:    state_in = S_RECT;
               brc_pkg::KIND_SPHERE:  state_in = status.dim_first ? S_RAD0 : S_SPH_SQ;
               brc_pkg::KIND_ELLIPSE: state_in = S_ELL_CHK;
               default:               state_in = S_NEXT_REG;
            endcase
         end
         S_RECT: state_in = status.rect_fail ? S_NEXT_REG : S_NEXT_DIM;
         S_RAD0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_src = brc_pkg::MUL_RADIUS;
            state_in    = S_RAD1;
         end
         S_RAD1: begin
            cmd.r2_load = 1'b1;
            state_in    = S_SPH_SQ;
         end
         S_SPH_SQ: begin
            if (status.sph_big) begin
               state_in = S_NEXT_REG;
            end else begin
               cmd.mul_en  = 1'b1;
               cmd.mul_src = brc_pkg::MUL_MAG;
               state_in    = S_SPH_ACC;
            end
         end
         S_SPH_ACC: begin
            cmd.sum_acc = 1'b1;
            state_in    = status.acc_fail ? S_NEXT_REG : S_NEXT_DIM;
         end
         S_ELL_CHK: begin
            if (status.axis_zero) begin
               state_in = status.mag_nz ? S_NEXT_REG : S_NEXT_DIM;
            end else if (status.ell_over) begin
               state_in = S_NEXT_REG;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = S_ELL_DIV;
            end
         end
         S_ELL_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_ELL_Q;
            end
         end
         S_ELL_Q: begin
            if (status.q_over) begin
               state_in = S_NEXT_REG;
            end else begin
               cmd.mul_en  = 1'b1;
               cmd.mul_src = brc_pkg::MUL_QUOT;
               state_in    = S_ELL_ACC;
            end
         end
         S_ELL_ACC: begin
            cmd.sum_acc = 1'b1;
            state_in    = status.acc_fail ? S_NEXT_REG : S_NEXT_DIM;
         end
         S_NEXT_DIM: begin
            if (status.dim_last) begin
               cmd.region_hit = 1'b1;
               state_in       = S_NEXT_REG;
            end else begin
               cmd.dim_inc = 1'b1;
               state_in    = S_GEO0;
            end
         end
         S_NEXT_REG: begin
            cmd.reg_inc = 1'b1;
            state_in    = S_REG_CHK;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
      end
   end

endmodule

// ===== rtl/brc_dpath.sv =====
// ----------------------------------------------------------------------------
// brc_dpath
// Datapath: configuration, region tables, distance arithmetic, divider,
// multiplier, basin accumulation and the result registers.
// ----------------------------------------------------------------------------
module brc_dpath #(
   parameter int MAX_REGIONS = brc_pkg::MAX_REGIONS
) (
   input  logic                clock,
   input  logic                reset,
   input  brc_pkg::cmd_type    cmd,
   output brc_pkg::status_type status,
   input  logic                csr_wr_en,
   input  logic [2:0]          csr_index,
   input  logic [30:0]         csr_wr_data,
   input  logic signed [31:0]  req_coord_zero,
   input  logic signed [31:0]  req_coord_one,
   input  logic signed [31:0]  req_coord_two,
   input  logic signed [31:0]  req_coord_three,
   input  logic [3:0]          req_region_index,
   input  logic [1:0]          req_dim_index,
   input  logic                req_word_select,
   input  logic signed [31:0]  req_word_value,
   input  logic [1:0]          req_region_kind,
   input  logic [7:0]          req_basin_mask,
   output logic                rsp_valid,
   output logic [3:0]          rsp_basin_now,
   output logic                rsp_entered_basin,
   output logic                rsp_commit_stop
);

   localparam int RIDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int RCNT_W = $clog2(MAX_REGIONS + 1);
   localparam int GA_W   = RIDX_W + brc_pkg::DIM_W + 1;

   // configuration
   logic [2:0]  dims_ff;
   logic [4:0]  nreg_ff;
   logic [3:0]  pmask_ff;
   logic        stop_ff;
   logic [30:0] period_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff  <= 3'd1;
         nreg_ff  <= 5'd1;
         pmask_ff <= 4'd0;
         stop_ff  <= 1'b1;
         for (int i = 0; i < 4; i++) begin
            period_ff[i] <= '0;
         end
      end else if (csr_wr_en) begin
         case (brc_pkg::csr_index_type'(csr_index))
            brc_pkg::CSR_DIMS:    dims_ff      <= csr_wr_data[2:0];
            brc_pkg::CSR_REGIONS: nreg_ff      <= csr_wr_data[4:0];
            brc_pkg::CSR_PMASK:   pmask_ff     <= csr_wr_data[3:0];
            brc_pkg::CSR_STOP:    stop_ff      <= csr_wr_data[0];
            brc_pkg::CSR_PERIOD0: period_ff[0] <= csr_wr_data;
            brc_pkg::CSR_PERIOD1: period_ff[1] <= csr_wr_data;
            brc_pkg::CSR_PERIOD2: period_ff[2] <= csr_wr_data;
            brc_pkg::CSR_PERIOD3: period_ff[3] <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // working registers
   logic signed [31:0] coord_ff [4];
   logic signed [31:0] coord_in [4];
   logic [RCNT_W-1:0]  reg_cnt_ff, reg_cnt_in;
   logic [1:0]         dim_cnt_ff, dim_cnt_in;
   logic [1:0]         kind_ff, kind_in;
   logic [7:0]         mask_ff, mask_in, hit_ff, hit_in;
   logic signed [31:0] w0_ff, w0_in, w1_ff, w1_in;
   logic signed [36:0] diff_ff, diff_in;
   logic [35:0]        mag_ff, mag_in;
   logic [31:0]        ax_ff, ax_in;
   logic [63:0]        prod_ff, prod_in, r2_ff, r2_in, sum_ff, sum_in;
   logic [32:0]        rem_ff, rem_in;
   logic [16:0]        q_ff, q_in;
   logic [4:0]         div_cnt_ff, div_cnt_in;
   logic [3:0]         cur_ff, cur_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [3:0]         basin_ff, basin_in;
   logic               entered_ff, entered_in, commit_ff, commit_in;

   // tables
   logic             geo_wr_en, kind_wr_en, in_range;
   logic [GA_W-1:0]  geo_wr_addr, geo_rd_addr;
   logic [31:0]      geo_rdata;
   logic [9:0]       kind_rdata;

   assign in_range    = (int'(req_region_index) < MAX_REGIONS);
   assign geo_wr_en   = cmd.wr_geo && in_range;
   assign kind_wr_en  = cmd.wr_kind && in_range;
   assign geo_wr_addr = {RIDX_W'(req_region_index), req_dim_index, req_word_select};
   assign geo_rd_addr = {reg_cnt_ff[RIDX_W-1:0], dim_cnt_ff, cmd.geo_sel};

   brc_ram #(.WIDTH(32), .ADDR_WIDTH(GA_W)) u_geo_ram (
      .clock   (clock),
      .wr_en   (geo_wr_en),
      .wr_addr (geo_wr_addr),
      .wr_data (req_word_value),
      .rd_addr (geo_rd_addr),
      .rd_data (geo_rdata)
   );

   brc_ram #(.WIDTH(10), .ADDR_WIDTH(RIDX_W)) u_kind_ram (
      .clock   (clock),
      .wr_en   (kind_wr_en),
      .wr_addr (RIDX_W'(req_region_index)),
      .wr_data ({req_region_kind, req_basin_mask}),
      .rd_addr (reg_cnt_ff[RIDX_W-1:0]),
      .rd_data (kind_rdata)
   );

   // one-step minimum-image reduction
   function automatic logic signed [36:0] reduce_fn(input logic signed [36:0] d,
                                                    input logic signed [36:0] p);
      logic signed [37:0] d2;
      d2 = 38'(d) <<< 1;
      if (d2 > 38'(p)) begin
         return d - p;
      end else if (d2 < -38'(p)) begin
         return d + p;
      end
      return d;
   endfunction

   logic signed [31:0] x_sel;
   logic               per_bit;
   logic signed [36:0] p_val, red;
   logic signed [32:0] span;
   logic [2:0]         dims_eff;
   logic [63:0]        sum_n, acc_limit, mul_res;
   logic [31:0]        opa, opb;
   logic               ge;
   logic [32:0]        tsub;
   logic [3:0]         found;

   assign x_sel   = coord_ff[dim_cnt_ff];
   assign per_bit = pmask_ff[dim_cnt_ff];
   // rectangles run in doubled units
   assign p_val   = (kind_ff == brc_pkg::KIND_RECT) ? {5'd0, period_ff[dim_cnt_ff], 1'b0}
                                                    : {6'd0, period_ff[dim_cnt_ff]};
   assign red     = per_bit ? reduce_fn(diff_ff, p_val) : diff_ff;
   assign span    = 33'(w1_ff) - 33'(w0_ff);
   assign dims_eff = (dims_ff == 3'd0) ? 3'd1 :
                     (dims_ff > 3'(brc_pkg::MAX_DIMS)) ? 3'(brc_pkg::MAX_DIMS) : dims_ff;
   assign sum_n     = sum_ff + prod_ff;
   assign acc_limit = (kind_ff == brc_pkg::KIND_SPHERE) ? r2_ff : brc_pkg::ONE_Q32;
   assign ge        = rem_ff >= {1'b0, ax_ff};
   assign tsub      = ge ? (rem_ff - {1'b0, ax_ff}) : rem_ff;

   always_comb begin
      case (cmd.mul_src)
         brc_pkg::MUL_RADIUS: begin
            opa = ax_ff;
            opb = ax_ff;
         end
         brc_pkg::MUL_MAG: begin
            opa = mag_ff[31:0];
            opb = mag_ff[31:0];
         end
         brc_pkg::MUL_QUOT: begin
            opa = {15'd0, q_ff};
            opb = {15'd0, q_ff};
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
      mul_res = 64'(opa) * 64'(opb);
   end

   // lowest basin among the containing regions
   always_comb begin
      found = 4'd0;
      for (int b = brc_pkg::BASIN_LIMIT - 1; b >= 0; b--) begin
         if (hit_ff[b]) begin
            found = 4'(b + 1);
         end
      end
   end

   always_comb begin
      status.region_done = (int'(reg_cnt_ff) >= int'(nreg_ff)) ||
                           (int'(reg_cnt_ff) >= MAX_REGIONS);
      status.skip_region = (kind_rdata[9:8] == brc_pkg::KIND_UNUSED) ||
                           ((kind_rdata[7:0] & brc_pkg::BASIN_SEL) == 8'd0);
      status.kind        = kind_ff;
      status.dim_first   = (dim_cnt_ff == 2'd0);
      status.dim_last    = ({1'b0, dim_cnt_ff} == (dims_eff - 3'd1));
      if (per_bit) begin
         status.rect_fail = (w0_ff <= w1_ff) ? (mag_ff >= 36'(span)) : (mag_ff < 36'(-span));
      end else begin
         status.rect_fail = (x_sel <= w0_ff) || (x_sel >= w1_ff);
      end
      status.sph_big   = mag_ff > brc_pkg::SPH_MAG_MAX;
      status.acc_fail  = sum_n > acc_limit;
      status.axis_zero = (ax_ff == 32'd0);
      status.mag_nz    = (mag_ff != 36'd0);
      status.ell_over  = mag_ff >= {3'd0, ax_ff, 1'b0};
      status.div_last  = (div_cnt_ff == 5'(brc_pkg::DIV_STEPS - 1));
      status.q_over    = q_ff > brc_pkg::Q_ONE;
   end

   always_comb begin
      coord_in     = coord_ff;
      reg_cnt_in   = reg_cnt_ff;
      dim_cnt_in   = dim_cnt_ff;
      kind_in      = kind_ff;
      mask_in      = mask_ff;
      hit_in       = hit_ff;
      w0_in        = w0_ff;
      w1_in        = w1_ff;
      diff_in      = diff_ff;
      mag_in       = mag_ff;
      ax_in        = ax_ff;
      prod_in      = prod_ff;
      r2_in        = r2_ff;
      sum_in       = sum_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      div_cnt_in   = div_cnt_ff;
      cur_in       = cur_ff;
      rsp_valid_in = cmd.finish;
      basin_in     = basin_ff;
      entered_in   = entered_ff;
      commit_in    = commit_ff;

      if (cmd.start_item) begin
         coord_in[0] = req_coord_zero;
         coord_in[1] = req_coord_one;
         coord_in[2] = req_coord_two;
         coord_in[3] = req_coord_three;
         reg_cnt_in  = '0;
         hit_in      = '0;
      end
      if (cmd.latch_kind) begin
         kind_in    = kind_rdata[9:8];
         mask_in    = kind_rdata[7:0];
         dim_cnt_in = '0;
         sum_in     = '0;
      end
      if (cmd.latch_w0) begin
         w0_in = geo_rdata;
      end
      if (cmd.latch_w1) begin
         w1_in = geo_rdata;
      end
      if (cmd.calc_diff) begin
         if (kind_ff == brc_pkg::KIND_RECT) begin
            diff_in = (37'(x_sel) <<< 1) - (37'(w0_ff) + 37'(w1_ff));
         end else begin
            diff_in = 37'(x_sel) - 37'(w0_ff);
         end
         ax_in = w1_ff[31] ? 32'(-33'(w1_ff)) : 32'(w1_ff);
      end
      if (cmd.calc_red) begin
         mag_in = red[36] ? 36'(-red) : 36'(red);
      end
      if (cmd.mul_en) begin
         prod_in = mul_res;
      end
      if (cmd.r2_load) begin
         r2_in = prod_ff;
      end
      if (cmd.sum_acc) begin
         sum_in = sum_n;
      end
      if (cmd.div_init) begin
         rem_in     = mag_ff[32:0];
         q_in       = '0;
         div_cnt_in = '0;
      end
      if (cmd.div_step) begin
         rem_in     = {tsub[31:0], 1'b0};
         q_in       = {q_ff[15:0], ge};
         div_cnt_in = div_cnt_ff + 5'd1;
      end
      if (cmd.dim_inc) begin
         dim_cnt_in = dim_cnt_ff + 2'd1;
      end
      if (cmd.region_hit) begin
         hit_in = hit_ff | mask_ff;
      end
      if (cmd.reg_inc) begin
         reg_cnt_in = reg_cnt_ff + RCNT_W'(1);
      end
      if (cmd.finish) begin
         basin_in   = found;
         entered_in = (found != 4'd0) && (found != cur_ff);
         commit_in  = (found != 4'd0) && stop_ff;
         cur_in     = found;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cur_ff       <= 4'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
      end
      coord_ff   <= coord_in;
      reg_cnt_ff <= reg_cnt_in;
      dim_cnt_ff <= dim_cnt_in;
      kind_ff    <= kind_in;
      mask_ff    <= mask_in;
      hit_ff     <= hit_in;
      w0_ff      <= w0_in;
      w1_ff      <= w1_in;
      diff_ff    <= diff_in;
      mag_ff     <= mag_in;
      ax_ff      <= ax_in;
      prod_ff    <= prod_in;
      r2_ff      <= r2_in;
      sum_ff     <= sum_in;
      rem_ff     <= rem_in;
      q_ff       <= q_in;
      div_cnt_ff <= div_cnt_in;
      basin_ff   <= basin_in;
      entered_ff <= entered_in;
      commit_ff  <= commit_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_basin_now     = basin_ff;
   assign rsp_entered_basin = entered_ff;
   assign rsp_commit_stop   = commit_ff;

endmodule

// ===== rtl/basin_region_classifier.sv =====
// ----------------------------------------------------------------------------
// basin_region_classifier
// Classifies a Q16.16 point into the first basin of a loaded region table.
//
//   channel   ports                     transaction
//   request   start/busy, req_*         start && !busy
//   response  rsp_valid, rsp_*          one-cycle strobe, no back-pressure
//   csr       csr_wr_en, csr_index/data every cycle csr_wr_en is high
//
// Table writes finish in their accept cycle. A classify walks the tested
// regions in turn and, within each, its dimensions in turn; an ellipse
// dimension runs the bit-serial divider (17 steps), and the single table
// read port serializes the geometry word reads. A region stops at its first
// failing dimension.
// Synchronous reset clears the previous basin, the strobe and the CSRs.
// The response strobe shows in the first cycle that busy is low again.
// ----------------------------------------------------------------------------
module basin_region_classifier #(
   parameter int MAX_REGIONS = brc_pkg::MAX_REGIONS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_operation,
   input  logic signed [31:0] req_coord_zero,
   input  logic signed [31:0] req_coord_one,
   input  logic signed [31:0] req_coord_two,
   input  logic signed [31:0] req_coord_three,
   input  logic [3:0]         req_region_index,
   input  logic [1:0]         req_dim_index,
   input  logic               req_word_select,
   input  logic signed [31:0] req_word_value,
   input  logic [1:0]         req_region_kind,
   input  logic [7:0]         req_basin_mask,
   output logic               rsp_valid,
   output logic [3:0]         rsp_basin_now,
   output logic               rsp_entered_basin,
   output logic               rsp_commit_stop,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [30:0]        csr_wr_data
);

   brc_pkg::cmd_type    cmd;
   brc_pkg::status_type status;

   brc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd),
      .busy          (busy)
   );

   brc_dpath #(.MAX_REGIONS(MAX_REGIONS)) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .req_coord_zero    (req_coord_zero),
      .req_coord_one     (req_coord_one),
      .req_coord_two     (req_coord_two),
      .req_coord_three   (req_coord_three),
      .req_region_index  (req_region_index),
      .req_dim_index     (req_dim_index),
      .req_word_select   (req_word_select),
      .req_word_value    (req_word_value),
      .req_region_kind   (req_region_kind),
      .req_basin_mask    (req_basin_mask),
      .rsp_valid         (rsp_valid),
      .rsp_basin_now     (rsp_basin_now),
      .rsp_entered_basin (rsp_entered_basin),
      .rsp_commit_stop   (rsp_commit_stop)
   );

endmodule

// ===== rtl/brc_checker.sv =====
// ----------------------------------------------------------------------------
// brc_checker
// Port-level checks of the classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "basin_region_classifier_assert.svh"

module brc_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [1:0] req_operation,
   input logic       rsp_valid,
   input logic [3:0] rsp_basin_now,
   input logic       rsp_entered_basin,
   input logic       rsp_commit_stop
);

   // result shows only after the sequencer is back in idle
   `BRC_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid, !busy)
   `BRC_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   `BRC_ASSERT_NOW(a_flags_need_basin, clock, reset, rsp_valid && (rsp_entered_basin || rsp_commit_stop), rsp_basin_now != 4'd0)
   `BRC_ASSERT_NOW(a_basin_range, clock, reset, rsp_valid, rsp_basin_now <= 4'(brc_pkg::BASIN_LIMIT))
   // table writes and unused codes finish in their accept cycle
   `BRC_ASSERT_NEXT(a_write_no_busy, clock, reset, start && !busy && (req_operation != brc_pkg::OP_CLASSIFY), !busy)

endmodule

bind basin_region_classifier brc_checker u_brc_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_operation     (req_operation),
   .rsp_valid         (rsp_valid),
   .rsp_basin_now     (rsp_basin_now),
   .rsp_entered_basin (rsp_entered_basin),
   .rsp_commit_stop   (rsp_commit_stop)
);

// ===== sim/basin_region_classifier_tb.sv =====
// ----------------------------------------------------------------------------
// basin_region_classifier_tb
// Self-checking bench: loads the region table, runs directed and random
// classify/write traffic across several register settings, and compares
// every response against a cycle-free prediction of the basin result.
// ----------------------------------------------------------------------------
module basin_region_classifier_tb;

   localparam int STALL_LIMIT = 20000;
   localparam int NUM_PHASES  = 10;
   localparam int PHASE_ITEMS = 85;

   typedef struct {
      logic [1:0]         op;
      logic signed [31:0] coord [4];
      logic [3:0]         region;
      logic [1:0]         dim;
      logic               sel;
      logic signed [31:0] value;
      logic [1:0]         kind;
      logic [7:0]         mask;
   } req_item_type;

   typedef struct {
      logic [3:0] basin;
      logic       entered;
      logic       stop;
   } basin_result_type;

   class basin_scoreboard;
      longint            geo_word [brc_pkg::MAX_REGIONS][brc_pkg::MAX_DIMS][2];
      logic [1:0]        kind_tab [brc_pkg::MAX_REGIONS];
      logic [7:0]        basin_tab [brc_pkg::MAX_REGIONS];
      logic [3:0]        prev_basin;
      logic [2:0]        dims_cfg;
      logic [4:0]        regions_cfg;
      logic [3:0]        pmask_cfg;
      logic              stop_cfg;
      longint            period [4];
      basin_result_type  pending [$];
      int                errors;

      function void init();
         prev_basin = 4'd0; dims_cfg = 3'd1; regions_cfg = 5'd1; pmask_cfg = 4'd0;
         stop_cfg = 1'b1;
         for (int i = 0; i < 4; i++) period[i] = 0;
         errors = 0;
      endfunction

      function void set_reg(int idx, logic [30:0] v);
         case (idx)
            brc_pkg::CSR_DIMS:    dims_cfg = v[2:0];
            brc_pkg::CSR_REGIONS: regions_cfg = v[4:0];
            brc_pkg::CSR_PMASK:   pmask_cfg = v[3:0];
            brc_pkg::CSR_STOP:    stop_cfg = v[0];
            default:              period[idx - brc_pkg::CSR_PERIOD0] = longint'(v);
         endcase
      endfunction

      function longint fold(longint d, longint p);
         if (2 * d > p) return d - p;
         if (2 * d < -p) return d + p;
         return d;
      endfunction

      function longint unsigned absval(longint v);
         return (v < 0) ? longint'(-v) : v;
      endfunction

      function bit in_region(int r, longint x [4], int dims);
         longint lo, hi, dd, dx;
         longint unsigned a, ax, q, t, r2, sum;
         sum = 0;
         case (kind_tab[r])
            brc_pkg::KIND_RECT: begin
               for (int d = 0; d < dims; d++) begin
                  lo = geo_word[r][d][0];
                  hi = geo_word[r][d][1];
                  if (pmask_cfg[d]) begin
                     // doubled units keep the midpoint exact
                     dd = fold(2 * x[d] - (lo + hi), 2 * period[d]);
                     a = absval(dd);
                     if (lo <= hi) begin
                        if (a >= longint'(hi - lo)) return 0;
                     end else begin
                        if (a < longint'(lo - hi)) return 0;
                     end
                  end else if (x[d] <= lo || x[d] >= hi) return 0;
               end
               return 1;
            end
            brc_pkg::KIND_SPHERE: begin
               a = absval(geo_word[r][0][1]);
               r2 = a * a;
               for (int d = 0; d < dims; d++) begin
                  dx = x[d] - geo_word[r][d][0];
                  if (pmask_cfg[d]) dx = fold(dx, period[d]);
                  a = absval(dx);
                  t = a * a;
                  sum = (t > ~64'd0 - sum) ? ~64'd0 : sum + t;
                  if (sum > r2) return 0;
               end
               return 1;
            end
            brc_pkg::KIND_ELLIPSE: begin
               for (int d = 0; d < dims; d++) begin
                  dx = x[d] - geo_word[r][d][0];
                  if (pmask_cfg[d]) dx = fold(dx, period[d]);
                  a = absval(dx);
                  ax = absval(geo_word[r][d][1]);
                  if (ax == 0) begin
                     if (a != 0) return 0;
                  end else begin
                     q = (a << 16) / ax;
                     if (q > 65536) return 0;
                     sum += q * q;
                     if (sum > brc_pkg::ONE_Q32) return 0;
                  end
               end
               return 1;
            end
            default: return 0;
         endcase
      endfunction

      function void note(req_item_type it);
         longint x [4];
         int dims, nreg;
         logic [3:0] found;
         basin_result_type res;
         case (it.op)
            brc_pkg::OP_WRITE_GEO: geo_word[it.region][it.dim][it.sel] = longint'(it.value);
            brc_pkg::OP_WRITE_KIND: begin
               kind_tab[it.region] = it.kind;
               basin_tab[it.region] = it.mask;
            end
            brc_pkg::OP_CLASSIFY: begin
               dims = int'(dims_cfg);
               if (dims < 1) dims = 1;
               if (dims > brc_pkg::MAX_DIMS) dims = brc_pkg::MAX_DIMS;
               nreg = int'(regions_cfg);
               if (nreg > brc_pkg::MAX_REGIONS) nreg = brc_pkg::MAX_REGIONS;
               for (int d = 0; d < 4; d++) x[d] = longint'(it.coord[d]);
               found = 4'd0;
               for (int b = 0; b < brc_pkg::MAX_BASINS && found == 0; b++)
                  for (int r = 0; r < nreg && found == 0; r++)
                     if (basin_tab[r][b] && in_region(r, x, dims)) found = 4'(b + 1);
               res.basin = found;
               res.entered = (found != 0 && found != prev_basin);
               res.stop = (found != 0 && stop_cfg);
               prev_basin = found;
               pending.insert(pending.size(), res);
            end
            default: ;
         endcase
      endfunction

      function void check(logic [3:0] b, logic e, logic s);
         basin_result_type exp_r;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response basin=%0d", $time, b);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (b !== exp_r.basin) begin
            $display("%0t: basin_now expected %0d actual %0d", $time, exp_r.basin, b);
            errors++;
         end
         if (e !== exp_r.entered) begin
            $display("%0t: entered_basin expected %0d actual %0d", $time, exp_r.entered, e);
            errors++;
         end
         if (s !== exp_r.stop) begin
            $display("%0t: commit_stop expected %0d actual %0d", $time, exp_r.stop, s);
            errors++;
         end
      endfunction
   endclass

   logic               clock, reset, start, busy;
   logic [1:0]         req_operation;
   logic signed [31:0] req_coord_zero, req_coord_one, req_coord_two, req_coord_three;
   logic [3:0]         req_region_index;
   logic [1:0]         req_dim_index;
   logic               req_word_select;
   logic signed [31:0] req_word_value;
   logic [1:0]         req_region_kind;
   logic [7:0]         req_basin_mask;
   logic               rsp_valid, rsp_entered_basin, rsp_commit_stop;
   logic [3:0]         rsp_basin_now;
   logic               csr_wr_en;
   logic [2:0]         csr_index;
   logic [30:0]        csr_wr_data;

   basin_scoreboard sb;
   int  stall_count;
   bit  no_idle;

   basin_region_classifier dut (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check(rsp_basin_now, rsp_entered_basin, rsp_commit_stop);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) stall_count <= 0;
      else if (stall_count >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else stall_count <= stall_count + 1;
   end

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function logic signed [31:0] near_value();
      return $signed($urandom_range(0, 32'h10_0000)) - 32'sh8_0000;
   endfunction

   // one transaction; start stays high when the next follows without a gap
   task automatic send(req_item_type it);
      int gap;
      start <= 1;
      req_operation <= it.op;
      req_coord_zero <= it.coord[0];
      req_coord_one <= it.coord[1];
      req_coord_two <= it.coord[2];
      req_coord_three <= it.coord[3];
      req_region_index <= it.region;
      req_dim_index <= it.dim;
      req_word_select <= it.sel;
      req_word_value <= it.value;
      req_region_kind <= it.kind;
      req_basin_mask <= it.mask;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note(it);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0 || busy) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_regs(logic [30:0] v [8]);
      for (int i = 0; i < 8; i++) begin
         csr_wr_en <= 1;
         csr_index <= brc_pkg::csr_index_type'(i);
         csr_wr_data <= v[i];
         @(posedge clock);
         sb.set_reg(i, v[i]);
      end
      csr_wr_en <= 0;
   endtask

   function req_item_type base_item(logic [1:0] op);
      req_item_type it;
      it.op = op;
      for (int d = 0; d < 4; d++) it.coord[d] = $urandom;
      it.region = $urandom; it.dim = $urandom; it.sel = $urandom;
      it.value = $urandom; it.kind = $urandom_range(0, 2); it.mask = $urandom;
      return it;
   endfunction

   function req_item_type random_item();
      req_item_type it;
      int r, pr;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         it = base_item(brc_pkg::OP_CLASSIFY);
         r = $urandom_range(0, 99);
         pr = $urandom_range(0, brc_pkg::MAX_REGIONS - 1);
         for (int d = 0; d < 4; d++) begin
            if (r < 70)
               it.coord[d] = 32'(sb.geo_word[pr][d][0]) + ($signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000);
            else if (r < 85) it.coord[d] = near_value();
         end
      end else if (r < 85) begin
         it = base_item(brc_pkg::OP_WRITE_GEO);
         if ($urandom_range(0, 9) != 0) begin
            if (it.sel == 0) it.value = near_value();
            else if ($urandom_range(0, 1)) it.value = $urandom_range(0, 32'h3_0000);
            else it.value = -$signed($urandom_range(0, 32'h3_0000));
         end
      end else if (r < 97) begin
         it = base_item(brc_pkg::OP_WRITE_KIND);
         if ($urandom_range(0, 7) == 0) it.kind = brc_pkg::KIND_UNUSED;
      end else it = base_item(2'd3);
      return it;
   endfunction

   initial begin
      req_item_type it;
      logic [30:0] regs [8];
      logic signed [31:0] c;
      sb = new();
      sb.init();
      reset = 1; start = 0; csr_wr_en = 0; csr_index = 0; csr_wr_data = 0;
      req_operation = 0; req_coord_zero = 0; req_coord_one = 0; req_coord_two = 0;
      req_coord_three = 0; req_region_index = 0; req_dim_index = 0; req_word_select = 0;
      req_word_value = 0; req_region_kind = 0; req_basin_mask = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // table load: every region gets every word before any classify
      no_idle = 0;
      for (int r = 0; r < brc_pkg::MAX_REGIONS; r++) begin
         for (int d = 0; d < brc_pkg::MAX_DIMS; d++) begin
            it = base_item(brc_pkg::OP_WRITE_GEO);
            it.region = r; it.dim = d; it.sel = 0;
            it.value = (r % 4 == 0) ? 32'sh1_0000 * r : 32'sh1_0000 * r + 32'sh8000;
            send(it);
            it.sel = 1;
            if (r % 4 == 0) it.value = 32'sh1_0000 * r + 32'sh2_0000;
            else if (r == 6 && d == 1) it.value = 0;
            else it.value = (r % 2) ? -32'sh1_0000 : 32'sh1_0000;
            send(it);
         end
         it = base_item(brc_pkg::OP_WRITE_KIND);
         it.region = r;
         it.kind = r % 4;
         it.mask = 8'd1 << (r % 8);
         send(it);
      end
      drain();

      // directed: wide settings, then points on centers, edges and extremes
      regs = '{3'd4, 5'd16, 4'd0, 1'd1, 31'd0, 31'd0, 31'd0, 31'd0};
      write_regs(regs);
      for (int k = 0; k < 20; k++) begin
         it = base_item(brc_pkg::OP_CLASSIFY);
         case (k)
            0: for (int d = 0; d < 4; d++) it.coord[d] = 32'sh1_0000;      // inside rect 0
            1: for (int d = 0; d < 4; d++) it.coord[d] = 32'sh0;           // rect open edge
            2: for (int d = 0; d < 4; d++) it.coord[d] = 32'sh2_0000;      // rect upper edge
            3: for (int d = 0; d < 4; d++) it.coord[d] = 32'sh1_8000;      // sphere center
            4: begin                                                         // sphere surface
               for (int d = 0; d < 4; d++) it.coord[d] = 32'sh1_8000;
               it.coord[0] = 32'sh2_8000;
            end
            5: for (int d = 0; d < 4; d++) it.coord[d] = 32'sh2_8000;      // ellipse center
            6: for (int d = 0; d < 4; d++) it.coord[d] = 32'sh6_8000;      // zero semi-axis
            7: begin
               for (int d = 0; d < 4; d++) it.coord[d] = 32'sh6_8000;
               it.coord[1] = 32'sh6_8001;
            end
            8: for (int d = 0; d < 4; d++) it.coord[d] = 32'sh3_8000;      // unused kind
            9: for (int d = 0; d < 4; d++) it.coord[d] = 32'sh8000_0000;
            10: for (int d = 0; d < 4; d++) it.coord[d] = 32'sh7fff_ffff;
            11: it.op = 2'd3;
            default: for (int d = 0; d < 4; d++) it.coord[d] = near_value();
         endcase
         send(it);
      end
      it = base_item(brc_pkg::OP_WRITE_GEO);
      it.region = 15; it.dim = 3; it.sel = 1; it.value = 32'sh8000_0000;
      send(it);
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         regs[brc_pkg::CSR_DIMS] = (p == 1) ? 0 : (p == 2) ? 7 : (p == 3) ? 1 : $urandom_range(1, 4);
         regs[brc_pkg::CSR_REGIONS] = (p == 1) ? 0 : (p == 2) ? 31 : (p == 3) ? 1 : $urandom_range(2, 16);
         regs[brc_pkg::CSR_PMASK] = (p == 0) ? 0 : (p == 2) ? 15 : $urandom_range(0, 15);
         regs[brc_pkg::CSR_STOP] = p % 2;
         for (int d = 0; d < 4; d++) begin
            c = $urandom_range(0, 3);
            if (p == 2) regs[brc_pkg::CSR_PERIOD0 + d] = 31'h7fff_ffff;
            else if (p == 3 || c == 0) regs[brc_pkg::CSR_PERIOD0 + d] = 0;
            else if (c == 3) regs[brc_pkg::CSR_PERIOD0 + d] = $urandom;
            else regs[brc_pkg::CSR_PERIOD0 + d] = $urandom_range(32'h4_0000, 32'h20_0000);
         end
         write_regs(regs);
         no_idle = (p % 3 == 2);
         for (int k = 0; k < PHASE_ITEMS; k++) send(random_item());
         drain();
      end

      if (sb.errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
